// File: hdl/midpoint_line_rasterizer_macros.svh
// ----------------------------------------------------------------------------
// midpoint line rasterizer assertion macros
// concurrent checks on clk, held off while arst_n is low
// ----------------------------------------------------------------------------
`ifndef MIDPOINT_LINE_RASTERIZER_MACROS_SVH
`define MIDPOINT_LINE_RASTERIZER_MACROS_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define MLR_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("mlr assertion failed");
// next-cycle implication
`define MLR_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("mlr assertion failed");
`else
`define MLR_ASSERT_NOW(label, ante, cons)
`define MLR_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// File: hdl/mlr_pkg.sv
// ----------------------------------------------------------------------------
// mlr_pkg
// widths, types and scale codes shared by the line rasterizer files
// ----------------------------------------------------------------------------
package mlr_pkg;

	localparam int COORD_W = 6;
	localparam int COLOR_W = 24;
	localparam int DIFF_W  = COORD_W + 1;
	// midpoint value stays within +-(2^COORD_W)*(2^(COORD_W+1)+2)*2
	localparam int ERR_W   = 2 * COORD_W + 4;

	typedef logic [COORD_W-1:0]       coord_t;
	typedef logic [COLOR_W-1:0]       color_t;
	typedef logic signed [DIFF_W-1:0] diff_t;
	typedef logic signed [ERR_W-1:0]  err_t;
	typedef logic signed [1:0]        dir_t;
	typedef logic signed [2:0]        mult_t;

	localparam mult_t K_ZERO    = 3'sd0;
	localparam mult_t K_ONE     = 3'sd1;
	localparam mult_t K_TWO     = 3'sd2;
	localparam mult_t K_NEG_ONE = -3'sd1;
	localparam mult_t K_NEG_TWO = -3'sd2;

	// operand request to the shared scale-and-add unit: a*ka + b*kb
	typedef struct packed {
		err_t  a;
		mult_t ka;
		err_t  b;
		mult_t kb;
	} mlr_op_t;

	function automatic mult_t dir_sum(dir_t d0, dir_t d1);
		return mult_t'(d0) + mult_t'(d1);
	endfunction

endpackage

// File: hdl/mlr_if.sv
// ----------------------------------------------------------------------------
// mlr channel interfaces
// line command channel and pixel channel, valid/ready handshake
// ----------------------------------------------------------------------------
interface mlr_cmd_if import mlr_pkg::*; ();
	logic   valid;
	logic   ready;
	coord_t start_x;
	coord_t start_y;
	coord_t end_x;
	coord_t end_y;
	color_t line_color;

	modport source (output valid, start_x, start_y, end_x, end_y, line_color, input ready);
	modport sink (input valid, start_x, start_y, end_x, end_y, line_color, output ready);
endinterface

interface mlr_pix_if import mlr_pkg::*; ();
	logic   valid;
	logic   ready;
	coord_t pixel_x;
	coord_t pixel_y;
	color_t pixel_color;
	logic   last_pixel;

	modport source (output valid, pixel_x, pixel_y, pixel_color, last_pixel, input ready);
	modport sink (input valid, pixel_x, pixel_y, pixel_color, last_pixel, output ready);
endinterface

// File: hdl/mlr_scale_add.sv
// ----------------------------------------------------------------------------
// mlr_scale_add
// shared arithmetic unit: a*ka + b*kb with ka, kb in -2..2
// ----------------------------------------------------------------------------
module mlr_scale_add import mlr_pkg::*; (
	input  mlr_op_t op,
	output err_t    sum
);

	function automatic err_t scale(err_t v, mult_t k);
		err_t r;
		case (k)
			K_ONE:     r = v;
			K_TWO:     r = v <<< 1;
			K_NEG_ONE: r = -v;
			K_NEG_TWO: r = -(v <<< 1);
			default:   r = '0;
		endcase
		return r;
	endfunction

	assign sum = scale(op.a, op.ka) + scale(op.b, op.kb);

endmodule

// File: hdl/midpoint_line_rasterizer.sv
// ----------------------------------------------------------------------------
// midpoint_line_rasterizer: once a command is taken, setup runs through DX, DY, OCT, F0, DP and DN,
// then RUN loads the first pixel; a line of n pixels streams one pixel per cycle when the sink keeps up
// cmd.ready returns once the last pixel is loaded into the output register
// the one shared scale-and-add unit does setup and every midpoint update
// reset clears the sequencer and the output valid
// ----------------------------------------------------------------------------
`include "midpoint_line_rasterizer_macros.svh"

module midpoint_line_rasterizer import mlr_pkg::*; #(
	parameter int MAX_DIM = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	mlr_cmd_if.sink       cmd,
	mlr_pix_if.source     pix
);

	localparam coord_t COORD_MAX = COORD_W'(MAX_DIM - 1);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_DX   = 3'd1;
	localparam logic [2:0] ST_DY   = 3'd2;
	localparam logic [2:0] ST_OCT  = 3'd3;
	localparam logic [2:0] ST_F0   = 3'd4;
	localparam logic [2:0] ST_DP   = 3'd5;
	localparam logic [2:0] ST_DN   = 3'd6;
	localparam logic [2:0] ST_RUN  = 3'd7;

	logic [2:0] state_q;
	logic       out_valid_q;

	coord_t x0_q, y0_q, x1_q, y1_q;
	coord_t x_q, y_q, steps_q;
	color_t color_q;
	diff_t  dx_q, dy_q;
	err_t   f_q, dp_q, dn_q;
	dir_t   pxs_q, pys_q, nxs_q, nys_q;
	logic   force_q;

	coord_t out_x_q, out_y_q;
	color_t out_color_q;
	logic   out_last_q;

	mlr_op_t op;
	err_t    sum;

	logic    load_out;
	logic    take_p;
	dir_t    mv_x, mv_y;

	// octant decode
	diff_t   adx_d, ady_d;
	coord_t  adx, ady;
	dir_t    oct_pxs, oct_pys, oct_nxs, oct_nys;
	coord_t  oct_steps, oct_x, oct_y;
	logic    oct_force;

	function automatic coord_t clamp(coord_t c);
		return (c > COORD_MAX) ? COORD_MAX : c;
	endfunction

	mlr_scale_add u_alu (
		.op  (op),
		.sum (sum)
	);

	assign cmd.ready = (state_q == ST_IDLE);
	assign load_out  = (state_q == ST_RUN) && (!out_valid_q || pix.ready);

	assign take_p = force_q ||
		(!dx_q[DIFF_W-1] ? !f_q[ERR_W-1] : (f_q[ERR_W-1] || (f_q == '0)));
	assign mv_x = take_p ? pxs_q : nxs_q;
	assign mv_y = take_p ? pys_q : nys_q;

	assign adx_d = dx_q[DIFF_W-1] ? -dx_q : dx_q;
	assign ady_d = dy_q[DIFF_W-1] ? -dy_q : dy_q;
	assign adx   = adx_d[COORD_W-1:0];
	assign ady   = ady_d[COORD_W-1:0];

	always_comb begin
		oct_pxs   = 2'sd0;
		oct_pys   = 2'sd0;
		oct_nxs   = 2'sd0;
		oct_nys   = 2'sd0;
		oct_steps = adx;
		oct_x     = x0_q;
		oct_y     = y0_q;
		oct_force = 1'b0;
		if (dx_q == '0) begin
			// vertical or single point, bottom up
			oct_pys   = 2'sd1;
			oct_steps = ady;
			oct_y     = dy_q[DIFF_W-1] ? y1_q : y0_q;
			oct_force = 1'b1;
		end else if (dy_q == '0) begin
			oct_pxs   = 2'sd1;
			oct_steps = adx;
			oct_x     = dx_q[DIFF_W-1] ? x1_q : x0_q;
			oct_force = 1'b1;
		end else if (!dx_q[DIFF_W-1]) begin
			if (!dy_q[DIFF_W-1]) begin
				if (ady < adx) begin
					oct_pxs = 2'sd1;  oct_pys = 2'sd0;  oct_nxs = 2'sd1;  oct_nys = 2'sd1;
					oct_steps = adx;
				end else begin
					oct_pxs = 2'sd1;  oct_pys = 2'sd1;  oct_nxs = 2'sd0;  oct_nys = 2'sd1;
					oct_steps = ady;
				end
			end else begin
				if (ady > adx) begin
					oct_pxs = 2'sd0;  oct_pys = -2'sd1; oct_nxs = 2'sd1;  oct_nys = -2'sd1;
					oct_steps = ady;
				end else begin
					oct_pxs = 2'sd1;  oct_pys = -2'sd1; oct_nxs = 2'sd1;  oct_nys = 2'sd0;
					oct_steps = adx;
				end
			end
		end else begin
			if (dy_q[DIFF_W-1]) begin
				if (ady < adx) begin
					oct_pxs = -2'sd1; oct_pys = -2'sd1; oct_nxs = -2'sd1; oct_nys = 2'sd0;
					oct_steps = adx;
				end else begin
					oct_pxs = 2'sd0;  oct_pys = -2'sd1; oct_nxs = -2'sd1; oct_nys = -2'sd1;
					oct_steps = ady;
				end
			end else begin
				if (ady > adx) begin
					oct_pxs = -2'sd1; oct_pys = 2'sd1;  oct_nxs = 2'sd0;  oct_nys = 2'sd1;
					oct_steps = ady;
				end else begin
					oct_pxs = -2'sd1; oct_pys = 2'sd0;  oct_nxs = -2'sd1; oct_nys = 2'sd1;
					oct_steps = adx;
				end
			end
		end
	end

	// operand selection for the shared unit
	always_comb begin
		op = '0;
		case (state_q)
			ST_DX: begin
				op.a  = err_t'({1'b0, x1_q});
				op.ka = K_ONE;
				op.b  = err_t'({1'b0, x0_q});
				op.kb = K_NEG_ONE;
			end
			ST_DY: begin
				op.a  = err_t'({1'b0, y1_q});
				op.ka = K_ONE;
				op.b  = err_t'({1'b0, y0_q});
				op.kb = K_NEG_ONE;
			end
			ST_F0: begin
				// 2*(dx*my - dy*mx) at the first midpoint
				op.a  = err_t'(dx_q);
				op.ka = dir_sum(pys_q, nys_q);
				op.b  = err_t'(dy_q);
				op.kb = -dir_sum(pxs_q, nxs_q);
			end
			ST_DP: begin
				op.a  = err_t'(dx_q);
				op.ka = dir_sum(pys_q, pys_q);
				op.b  = err_t'(dy_q);
				op.kb = -dir_sum(pxs_q, pxs_q);
			end
			ST_DN: begin
				op.a  = err_t'(dx_q);
				op.ka = dir_sum(nys_q, nys_q);
				op.b  = err_t'(dy_q);
				op.kb = -dir_sum(nxs_q, nxs_q);
			end
			ST_RUN: begin
				op.a  = f_q;
				op.ka = K_ONE;
				op.b  = take_p ? dp_q : dn_q;
				op.kb = K_ONE;
			end
			default: begin
				op = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: if (cmd.valid) state_q <= ST_DX;
				ST_DX:   state_q <= ST_DY;
				ST_DY:   state_q <= ST_OCT;
				ST_OCT:  state_q <= ST_F0;
				ST_F0:   state_q <= ST_DP;
				ST_DP:   state_q <= ST_DN;
				ST_DN:   state_q <= ST_RUN;
				ST_RUN:  if (load_out && steps_q == '0) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (cmd.valid) begin
					x0_q    <= clamp(cmd.start_x);
					y0_q    <= clamp(cmd.start_y);
					x1_q    <= clamp(cmd.end_x);
					y1_q    <= clamp(cmd.end_y);
					color_q <= cmd.line_color;
				end
			end
			ST_DX: dx_q <= sum[DIFF_W-1:0];
			ST_DY: dy_q <= sum[DIFF_W-1:0];
			ST_OCT: begin
				pxs_q   <= oct_pxs;
				pys_q   <= oct_pys;
				nxs_q   <= oct_nxs;
				nys_q   <= oct_nys;
				steps_q <= oct_steps;
				x_q     <= oct_x;
				y_q     <= oct_y;
				force_q <= oct_force;
			end
			ST_F0: f_q  <= sum;
			ST_DP: dp_q <= sum;
			ST_DN: dn_q <= sum;
			ST_RUN: begin
				if (load_out && steps_q != '0) begin
					x_q     <= x_q + coord_t'(mv_x);
					y_q     <= y_q + coord_t'(mv_y);
					f_q     <= sum;
					steps_q <= steps_q - coord_t'(1);
				end
			end
			default: begin
			end
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (pix.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_x_q     <= x_q;
			out_y_q     <= y_q;
			out_color_q <= color_q;
			out_last_q  <= (steps_q == '0);
		end
	end

	assign pix.valid       = out_valid_q;
	assign pix.pixel_x     = out_x_q;
	assign pix.pixel_y     = out_y_q;
	assign pix.pixel_color = out_color_q;
	assign pix.last_pixel  = out_last_q;

	`MLR_ASSERT_NEXT(a_cmd_starts_setup, cmd.valid && cmd.ready, state_q == ST_DX)
	`MLR_ASSERT_NEXT(a_last_ends_line, load_out && steps_q == '0, state_q == ST_IDLE)
	`MLR_ASSERT_NOW(a_pos_in_grid, state_q == ST_RUN, x_q <= COORD_MAX && y_q <= COORD_MAX)
	`MLR_ASSERT_NEXT(a_load_sets_valid, load_out, out_valid_q)

endmodule
